FILE: src/foc_voltage_torque_to_pwm_assert.svh
// Assertion macros for the voltage-to-PWM block
`ifndef FOC_VOLTAGE_TORQUE_TO_PWM_ASSERT_SVH
`define FOC_VOLTAGE_TORQUE_TO_PWM_ASSERT_SVH

// same-cycle implication
`define FVTP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fvtp assertion failed");

// next-cycle implication
`define FVTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fvtp assertion failed");

`endif

FILE: src/fvtp_pkg.sv
`timescale 1ns / 1ps
package fvtp_pkg;

    localparam int ANGLE_BITS       = 16;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int IDX_BITS         = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER          = SINE_TABLE_DEPTH / 4;
    localparam int QUOT_BITS        = 16;
    localparam int LANES            = 3;

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint SIN_A   = 64'sd1686629713;
    localparam longint SIN_B   = 64'sd688904866;
    localparam longint SIN_C   = 64'sd76017977;
    localparam longint Z_STEP  = ONE_Q30 / QUARTER;

    localparam logic [14:0] SUPPLY_RESET = 15'd3072;
    localparam logic [14:0] LIMIT_RESET  = 15'd3072;
    localparam logic [15:0] PERIOD_RESET = 16'd5500;
    localparam logic signed [15:0] SQRT3_Q13 = 16'sd14189;

    typedef enum logic [1:0] {
        REG_SUPPLY = 2'd0,
        REG_LIMIT  = 2'd1,
        REG_PERIOD = 2'd2
    } reg_index_t;

    typedef logic [14:0] sine_lut_t [0:QUARTER];

    typedef struct packed {
        logic [14:0] rem;
        logic [15:0] word;
    } div_lane_t;

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t lut;
        longint z;
        longint z2;
        longint t;
        longint u;
        longint s30;
        longint s15;
        for (int k = 0; k <= QUARTER; k++)
        begin
            z   = longint'(k) * Z_STEP;
            z2  = (z * z) / ONE_Q30;
            t   = SIN_B - (z2 * SIN_C) / ONE_Q30;
            u   = SIN_A - (z2 * t) / ONE_Q30;
            s30 = (z * u) / ONE_Q30;
            s15 = (s30 + 16384) / 32768;
            if (s15 > 32767)
            begin
                s15 = 32767;
            end
            lut[k] = s15[14:0];
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine_lut();

    function automatic logic signed [15:0] sine_at(input logic [IDX_BITS-1:0] idx);
        logic [1:0]          quad;
        logic [IDX_BITS-3:0] r;
        logic [IDX_BITS-2:0] k;
        logic [15:0]         mag;
        quad = idx[IDX_BITS-1 -: 2];
        r    = idx[IDX_BITS-3:0];
        k    = quad[0] ? (IDX_BITS-1)'(QUARTER) - {1'b0, r} : {1'b0, r};
        mag  = {1'b0, SINE_LUT[k]};
        return quad[1] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

FILE: src/fvtp_if.sv
`timescale 1ns / 1ps
interface fvtp_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] torque_voltage;
    logic [15:0]        electrical_angle;

    modport source (output valid, output torque_voltage, output electrical_angle, input ready);
    modport sink (input valid, input torque_voltage, input electrical_angle, output ready);
endinterface

interface fvtp_cmp_if;
    logic        valid;
    logic        ready;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;

    modport source (output valid, output compare_a, output compare_b, output compare_c,
                    input ready);
    modport sink (input valid, input compare_a, input compare_b, input compare_c,
                  output ready);
endinterface

FILE: src/fvtp_front.sv
`timescale 1ns / 1ps
module fvtp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [15:0]            torque_voltage,
    input  logic [15:0]                   electrical_angle,
    input  logic [14:0]                   supply,
    input  logic [14:0]                   limit,
    input  logic [15:0]                   period,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fvtp_pkg::div_lane_t [2:0]     lane
);
    import fvtp_pkg::*;

    logic [6:1] v_reg;
    logic [7:1] adv;

    logic signed [15:0] uq_reg, s_reg, c_reg;
    logic signed [15:0] uq_next, s_next, c_next;
    logic signed [31:0] p1_reg, p2_reg;
    logic signed [47:0] a_reg, sq_reg;
    logic signed [47:0] a_next;
    logic signed [46:0] sq_next;
    logic [44:0]        m_reg [LANES];
    logic [44:0]        m_next [LANES];
    logic [30:0]        hi_reg [LANES];
    logic [15:0]        lo_reg [LANES];
    logic [45:0]        lo_full [LANES];
    div_lane_t [2:0]    lane_reg;
    div_lane_t [2:0]    lane_next;

    logic signed [16:0]   tq2;
    logic signed [16:0]   sup_s;
    logic [IDX_BITS-1:0]  idx;
    logic signed [47:0]   half;
    logic signed [47:0]   ph [LANES];
    logic [14:0]          capv;
    logic [44:0]          cap;
    logic [30:0]          x [LANES];

    always_comb
    begin
        adv[7] = out_ready;
        for (int k = 6; k >= 1; k--)
        begin
            adv[k] = ~v_reg[k] | adv[k+1];
        end
    end

    assign in_ready  = adv[1];
    assign out_valid = v_reg[6];
    assign lane      = lane_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int k = 2; k <= 6; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        tq2   = {torque_voltage, 1'b0};
        sup_s = $signed({2'b00, supply});
        if (tq2 > sup_s)
        begin
            uq_next = sup_s[15:0];
        end
        else if (tq2 < -sup_s)
        begin
            uq_next = 16'(-sup_s);
        end
        else
        begin
            uq_next = tq2[15:0];
        end
        idx    = electrical_angle[ANGLE_BITS-1 -: IDX_BITS];
        s_next = sine_at(idx);
        c_next = sine_at(idx + IDX_BITS'(QUARTER));
    end

    always_comb
    begin
        a_next  = -(48'(p1_reg) <<< 13);
        sq_next = p2_reg * SQRT3_Q13;
    end

    always_comb
    begin
        half  = $signed({4'b0, supply, 29'b0});
        capv  = (limit < supply) ? limit : supply;
        cap   = {capv, 30'b0};
        ph[0] = (a_reg <<< 1) + half;
        ph[1] = sq_reg - a_reg + half;
        ph[2] = -a_reg - sq_reg + half;
        for (int i = 0; i < LANES; i++)
        begin
            if (ph[i] <= 48'sd0)
            begin
                m_next[i] = '0;
            end
            else if (ph[i] > $signed({3'b000, cap}))
            begin
                m_next[i] = cap;
            end
            else
            begin
                m_next[i] = ph[i][44:0];
            end
            lo_full[i] = m_reg[i][29:0] * period;
            x[i]       = hi_reg[i] + 31'(lo_reg[i]);
            lane_next[i].rem  = x[i][30:16];
            lane_next[i].word = x[i][15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            uq_reg <= uq_next;
            s_reg  <= s_next;
            c_reg  <= c_next;
        end
        if (adv[2])
        begin
            p1_reg <= uq_reg * s_reg;
            p2_reg <= uq_reg * c_reg;
        end
        if (adv[3])
        begin
            a_reg  <= a_next;
            sq_reg <= 48'(sq_next);
        end
        for (int i = 0; i < LANES; i++)
        begin
            if (adv[4])
            begin
                m_reg[i] <= m_next[i];
            end
            if (adv[5])
            begin
                hi_reg[i] <= m_reg[i][44:30] * period;
                lo_reg[i] <= lo_full[i][45:30];
            end
        end
        if (adv[6])
        begin
            lane_reg <= lane_next;
        end
    end

endmodule

FILE: src/fvtp_div_cell.sv
`timescale 1ns / 1ps
module fvtp_div_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [14:0]               divisor,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  fvtp_pkg::div_lane_t [2:0] lane_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output fvtp_pkg::div_lane_t [2:0] lane_out
);
    import fvtp_pkg::*;

    logic            valid_reg;
    div_lane_t [2:0] lane_reg;
    div_lane_t [2:0] lane_next;
    logic [15:0]     trial [LANES];
    logic            ge [LANES];

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign lane_out  = lane_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            trial[i] = {lane_in[i].rem, lane_in[i].word[15]};
            ge[i]    = trial[i] >= {1'b0, divisor};
            lane_next[i].rem  = ge[i] ? 15'(trial[i] - {1'b0, divisor}) : trial[i][14:0];
            lane_next[i].word = {lane_in[i].word[14:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            lane_reg <= lane_next;
        end
    end

endmodule

FILE: src/foc_voltage_torque_to_pwm.sv
`timescale 1ns / 1ps
// Voltage-mode FOC output stage: q-axis voltage and electrical angle in,
// three PWM timer compare values out.
// cmd channel: torque_voltage (signed Q8.8 V) and electrical_angle (turn
// fraction); one beat in gives exactly one beat out on the cmp channel.
// A cmd beat passes 22 register stages: six datapath stages (clamp and sine
// lookup, two multiply stages, phase clamp, period scaling, sum) and a row
// of 16 divider cells, one quotient bit per cell.
// Throughput is one beat per cycle while the receiver takes beats; every
// stage holds its own valid bit.
// When the receiver stalls, the last cell holds its beat and stages behind it
// keep filling until they are all full; only then does cmd ready drop.
// The user must write the registers over the APB port only while the block
// is idle (not enforced here): 0x0 supply_voltage, 0x4 phase_voltage_limit,
// 0x8 pwm_period. Reset empties the pipeline and loads 12 V supply and limit
// and a period of 5500. A zero supply drives all compare values to zero.
module foc_voltage_torque_to_pwm (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    fvtp_cmd_if.sink    cmd,
    fvtp_cmp_if.source  cmp
);
    import fvtp_pkg::*;

    logic [14:0] supply_reg;
    logic [14:0] limit_reg;
    logic [15:0] pwm_period_reg;
    logic        wr;

    logic            valid_w [QUOT_BITS+1];
    logic            ready_w [QUOT_BITS+1];
    div_lane_t [2:0] lane_w  [QUOT_BITS+1];

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg     <= SUPPLY_RESET;
            limit_reg      <= LIMIT_RESET;
            pwm_period_reg <= PERIOD_RESET;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_SUPPLY: supply_reg     <= pwdata[14:0];
                REG_LIMIT:  limit_reg      <= pwdata[14:0];
                REG_PERIOD: pwm_period_reg <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SUPPLY: prdata = {17'b0, supply_reg};
            REG_LIMIT:  prdata = {17'b0, limit_reg};
            REG_PERIOD: prdata = {16'b0, pwm_period_reg};
            default:    prdata = '0;
        endcase
    end

    fvtp_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (cmd.valid),
        .in_ready         (cmd.ready),
        .torque_voltage   (cmd.torque_voltage),
        .electrical_angle (cmd.electrical_angle),
        .supply           (supply_reg),
        .limit            (limit_reg),
        .period           (pwm_period_reg),
        .out_valid        (valid_w[0]),
        .out_ready        (ready_w[0]),
        .lane             (lane_w[0])
    );

    for (genvar g = 0; g < QUOT_BITS; g++)
    begin : g_cell
        fvtp_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .divisor   (supply_reg),
            .in_valid  (valid_w[g]),
            .in_ready  (ready_w[g]),
            .lane_in   (lane_w[g]),
            .out_valid (valid_w[g+1]),
            .out_ready (ready_w[g+1]),
            .lane_out  (lane_w[g+1])
        );
    end

    assign ready_w[QUOT_BITS] = cmp.ready;
    assign cmp.valid     = valid_w[QUOT_BITS];
    assign cmp.compare_a = (supply_reg == '0) ? '0 : lane_w[QUOT_BITS][0].word;
    assign cmp.compare_b = (supply_reg == '0) ? '0 : lane_w[QUOT_BITS][1].word;
    assign cmp.compare_c = (supply_reg == '0) ? '0 : lane_w[QUOT_BITS][2].word;

`include "foc_voltage_torque_to_pwm_assert.svh"

    `FVTP_ASSERT_IMP(a_stall_only_backpressure, !cmd.ready, cmp.valid && !cmp.ready)
    `FVTP_ASSERT_IMP(a_cmp_in_range, cmp.valid,
        cmp.compare_a <= pwm_period_reg && cmp.compare_b <= pwm_period_reg &&
        cmp.compare_c <= pwm_period_reg)
    `FVTP_ASSERT_NEXT(a_period_write, wr && paddr[3:2] == REG_PERIOD,
        pwm_period_reg == $past(pwdata[15:0]))

endmodule
